// ===== sv/rc5_pkg.sv =====
// ---------------------------------------------------------------------------
// rc5_pkg
// Shared types, codes and word functions for the RC5-32 block cipher core.
// ---------------------------------------------------------------------------
package rc5_pkg;

    localparam logic [31:0] MAGIC_P = 32'hB7E15163;
    localparam logic [31:0] MAGIC_Q = 32'h9E3779B9;
    localparam logic [4:0]  MIX_ROT = 5'd3;

    localparam logic [1:0] CMD_ENCRYPT = 2'd0;
    localparam logic [1:0] CMD_DECRYPT = 2'd1;
    localparam logic [1:0] CMD_REKEY   = 2'd2;

    localparam logic [1:0] KIND_CIPHER  = 2'd0;
    localparam logic [1:0] KIND_PLAIN   = 2'd1;
    localparam logic [1:0] KIND_KEYDONE = 2'd2;

    localparam logic REG_KEY_LOW  = 1'b0;
    localparam logic REG_KEY_HIGH = 1'b1;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] word_a;
        logic [31:0] word_b;
    } item_t;

    typedef struct packed {
        logic [31:0] out_a;
        logic [31:0] out_b;
        logic [1:0]  kind;
    } result_t;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] t;
        t = {x, x} << n;
        return t[63:32];
    endfunction

    function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] t;
        t = {x, x} >> n;
        return t[31:0];
    endfunction

endpackage

// ===== sv/rc5_block_cipher_core.sv =====
// ---------------------------------------------------------------------------
// rc5_block_cipher_core
// RC5-32 encrypt, decrypt and key schedule on one half-round datapath.
// ---------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result appears on
// result for exactly one cycle with done high and cannot be held off. One
// half-round (or half mixing step) runs per cycle on a shared datapath fed by
// a round key memory with one write port and one registered read port:
// encrypt and decrypt step through the table once, rekey mixes over it three
// times. busy stays high until the result is shown, and a new item may be
// started in the cycle done is shown.
module rc5_block_cipher_core
    import rc5_pkg::*;
#(
    parameter int ROUNDS    = 12,
    parameter int KEY_BYTES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  item_t       item,
    output logic        done,
    output result_t     result,
    input  logic        cfg_we,
    input  logic        cfg_idx,
    input  logic [63:0] cfg_data
);

    localparam int TSIZE  = 2 * (ROUNDS + 1);
    localparam int KWORDS = (KEY_BYTES + 3) / 4;
    localparam int IDX_W  = $clog2(TSIZE);
    localparam int KW_W   = (KWORDS > 1) ? $clog2(KWORDS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TSIZE - 1);
    localparam logic [KW_W-1:0]  LAST_KW  = KW_W'(KWORDS - 1);

    typedef enum logic [1:0] {ST_IDLE, ST_CIPHER, ST_MIX} state_t;

    state_t            state_reg, state_next;
    logic [31:0]       a_reg, a_next;
    logic [31:0]       b_reg, b_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [KW_W-1:0]   j_reg, j_next;
    logic [1:0]        pass_reg, pass_next;
    logic              phase_reg, phase_next;
    logic              dec_reg, dec_next;
    logic [31:0]       s_init_reg, s_init_next;
    logic              table_valid_reg, table_valid_next;
    logic              done_reg, done_next;
    result_t           result_reg, result_next;
    logic [63:0]       key_low_reg, key_high_reg;
    logic [31:0]       key_words_reg [KWORDS];
    logic [31:0]       key_words_next [KWORDS];
    logic [31:0]       key_load [KWORDS];
    logic [127:0]      key_vec;

    logic [31:0]       mem [TSIZE];
    logic [31:0]       rd_data_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic              mem_we;
    logic [31:0]       mem_wdata;

    logic [31:0]       key_val;
    logic [31:0]       ab_sum;
    logic [31:0]       mix_src;
    logic [IDX_W-1:0]  idx_inc;
    logic              accept;

    assign busy    = (state_reg != ST_IDLE);
    assign accept  = start && !busy;
    assign done    = done_reg;
    assign result  = result_reg;
    assign key_val = table_valid_reg ? rd_data_reg : 32'd0;
    assign ab_sum  = a_reg + b_reg;
    assign mix_src = (pass_reg == 2'd0) ? s_init_reg : key_val;
    assign idx_inc = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
    assign key_vec = {key_high_reg, key_low_reg};

    // key bytes packed little-endian into words
    always_comb
    begin
        for (int w = 0; w < KWORDS; w++)
        begin
            key_load[w] = '0;
            for (int k = 0; k < 4; k++)
            begin
                if (4 * w + k < KEY_BYTES)
                begin
                    key_load[w][8*k +: 8] = key_vec[8*(4*w+k) +: 8];
                end
            end
        end
    end

    always_comb
    begin
        case (state_reg)
            ST_IDLE:
            begin
                rd_addr = item.cmd[0] ? LAST_IDX : '0;
            end
            ST_CIPHER:
            begin
                if (dec_reg)
                begin
                    rd_addr = (idx_reg == '0) ? '0 : idx_reg - 1'b1;
                end
                else
                begin
                    rd_addr = (idx_reg == LAST_IDX) ? LAST_IDX : idx_reg + 1'b1;
                end
            end
            ST_MIX:
            begin
                rd_addr = phase_reg ? idx_inc : idx_reg;
            end
            default:
            begin
                rd_addr = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        idx_next         = idx_reg;
        j_next           = j_reg;
        pass_next        = pass_reg;
        phase_next       = phase_reg;
        dec_next         = dec_reg;
        s_init_next      = s_init_reg;
        table_valid_next = table_valid_reg;
        done_next        = 1'b0;
        result_next      = result_reg;
        mem_we           = 1'b0;
        mem_wdata        = '0;
        for (int w = 0; w < KWORDS; w++)
        begin
            key_words_next[w] = key_words_reg[w];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.cmd[1])
                    begin
                        state_next       = ST_MIX;
                        a_next           = '0;
                        b_next           = '0;
                        idx_next         = '0;
                        j_next           = '0;
                        pass_next        = 2'd0;
                        phase_next       = 1'b0;
                        s_init_next      = MAGIC_P;
                        table_valid_next = 1'b1;
                        for (int w = 0; w < KWORDS; w++)
                        begin
                            key_words_next[w] = key_load[w];
                        end
                    end
                    else
                    begin
                        state_next = ST_CIPHER;
                        a_next     = item.word_a;
                        b_next     = item.word_b;
                        dec_next   = item.cmd[0];
                        idx_next   = item.cmd[0] ? LAST_IDX : '0;
                    end
                end
            end
            ST_CIPHER:
            begin
                if (!dec_reg)
                begin
                    if (!idx_reg[0])
                    begin
                        a_next = ((idx_reg == '0) ? a_reg : rotl32(a_reg ^ b_reg, b_reg[4:0]))
                                 + key_val;
                    end
                    else
                    begin
                        b_next = ((idx_reg == IDX_W'(1)) ? b_reg
                                 : rotl32(b_reg ^ a_reg, a_reg[4:0])) + key_val;
                    end
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    if (idx_reg[0])
                    begin
                        b_next = (idx_reg == IDX_W'(1)) ? b_reg - key_val
                                 : rotr32(b_reg - key_val, a_reg[4:0]) ^ a_reg;
                    end
                    else
                    begin
                        a_next = (idx_reg == '0) ? a_reg - key_val
                                 : rotr32(a_reg - key_val, b_reg[4:0]) ^ b_reg;
                    end
                    idx_next = idx_reg - 1'b1;
                end
                if ((!dec_reg && idx_reg == LAST_IDX) || (dec_reg && idx_reg == '0))
                begin
                    state_next        = ST_IDLE;
                    idx_next          = '0;
                    done_next         = 1'b1;
                    result_next.out_a = a_next;
                    result_next.out_b = b_next;
                    result_next.kind  = dec_reg ? KIND_PLAIN : KIND_CIPHER;
                end
            end
            ST_MIX:
            begin
                if (!phase_reg)
                begin
                    a_next      = rotl32(mix_src + ab_sum, MIX_ROT);
                    mem_we      = 1'b1;
                    mem_wdata   = a_next;
                    s_init_next = s_init_reg + MAGIC_Q;
                    phase_next  = 1'b1;
                end
                else
                begin
                    b_next             = rotl32(key_words_reg[j_reg] + ab_sum, ab_sum[4:0]);
                    key_words_next[j_reg] = b_next;
                    idx_next           = idx_inc;
                    j_next             = (j_reg == LAST_KW) ? '0 : j_reg + 1'b1;
                    phase_next         = 1'b0;
                    if (idx_reg == LAST_IDX)
                    begin
                        pass_next = pass_reg + 2'd1;
                        if (pass_reg == 2'd2)
                        begin
                            state_next        = ST_IDLE;
                            pass_next         = 2'd0;
                            done_next         = 1'b1;
                            result_next.out_a = '0;
                            result_next.out_b = '0;
                            result_next.kind  = KIND_KEYDONE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            a_reg           <= '0;
            b_reg           <= '0;
            idx_reg         <= '0;
            j_reg           <= '0;
            pass_reg        <= 2'd0;
            phase_reg       <= 1'b0;
            dec_reg         <= 1'b0;
            s_init_reg      <= '0;
            table_valid_reg <= 1'b0;
            done_reg        <= 1'b0;
            result_reg      <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            a_reg           <= a_next;
            b_reg           <= b_next;
            idx_reg         <= idx_next;
            j_reg           <= j_next;
            pass_reg        <= pass_next;
            phase_reg       <= phase_next;
            dec_reg         <= dec_next;
            s_init_reg      <= s_init_next;
            table_valid_reg <= table_valid_next;
            done_reg        <= done_next;
            result_reg      <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_KEY_LOW:  key_low_reg  <= cfg_data;
                REG_KEY_HIGH: key_high_reg <= cfg_data;
                default:      key_low_reg  <= key_low_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        for (int w = 0; w < KWORDS; w++)
        begin
            key_words_reg[w] <= key_words_next[w];
        end
    end

    // round key memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[idx_reg] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("transfer accepted but core not busy");

    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(busy))
        else $error("result strobe without work in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.kind == KIND_KEYDONE) |-> (result.out_a == '0 && result.out_b == '0))
        else $error("key schedule result carries nonzero words");

endmodule
